[sv/gbc_pkg.sv]
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and constants for the clamped 3x3 Gaussian blur.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned OP_DEPTH     = 4;
  localparam int unsigned OUT_DEPTH    = 4;
  localparam int unsigned OUT_CNT_W    = 3;
  localparam int unsigned RES_W        = 9;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BM_NORMAL = 2'd0,
    BM_LEFT   = 2'd1,
    BM_RIGHT  = 2'd2,
    BM_ALL2   = 2'd3
  } blur_mode_t;

  typedef struct packed {
    logic       flush;
    logic       r0;
    logic       r1;
    logic       emit;
    logic       last;
    blur_mode_t mode;
    logic [7:0] pix;
  } op_ctl_t;

  localparam int unsigned OP_CTL_W = $bits(op_ctl_t);

  function automatic logic [9:0] col_sum(input logic [7:0] t, input logic [7:0] m,
                                         input logic [7:0] b);
    col_sum = {2'b00, t} + {1'b0, m, 1'b0} + {2'b00, b};
  endfunction

endpackage

[sv/gaussian_blur_3x3_clamped_top.sv]
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_clamped_top
// Streaming 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1, sum / 16) with edge clamp.
//
// Pixels enter in raster order on the input channel (cmd 0 with pixel_in).
// A result for a pixel appears once the pixel one row and one column later
// has been sent; after the last pixel of a frame, send flush requests
// (cmd 1), one per pending result. frame_last marks the last result.
// The configuration channel writes image_width (index 0) or image_height
// (index 1); each write restarts the frame and must be done while idle.
// One request is accepted per cycle while the op queue has room. A result
// passes through the op queue and the line store read register before it is
// written into the output queue, and out_valid rises once it is there. In a
// single-row frame the first flush request issues an extra step, with
// in_ready low until that step is queued. When the receiver stalls, the
// four-entry output queue fills and the back end stops taking work; the op
// queue then fills and input ready drops. Reset empties both queues, clears
// the window and frame counters and sets the size to 640 x 480.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_clamped_top import gbc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [7:0]            pixel_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            pixel_out,
  output logic                  frame_last,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned QW  = CW + OP_CTL_W;

  logic                 f_push;
  logic [CW-1:0]        f_col;
  op_ctl_t              f_ctl;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic [QW-1:0]        q_dout;
  logic [$clog2(OP_DEPTH+1)-1:0] q_count;
  logic                 res_push;
  logic [RES_W-1:0]     res_data;
  logic [RES_W-1:0]     o_dout;
  logic                 o_full;
  logic                 o_empty;
  logic [OUT_CNT_W-1:0] o_count;
  logic                 o_pop;

  assign cfg_ready = 1'b1;

  gbc_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .pixel_in (pixel_in),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_col    (f_col),
    .q_ctl    (f_ctl)
  );

  gbc_fifo #(
    .W    (QW),
    .DEPTH(OP_DEPTH)
  ) u_op_q (
    .clk  (clk),
    .rst  (rst),
    .push (f_push),
    .din  ({f_col, f_ctl}),
    .pop  (q_pop),
    .dout (q_dout),
    .full (q_full),
    .empty(q_empty),
    .count(q_count)
  );

  gbc_back #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW       (CW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_col    (q_dout[QW-1:OP_CTL_W]),
    .q_ctl    (op_ctl_t'(q_dout[OP_CTL_W-1:0])),
    .q_pop    (q_pop),
    .out_count(o_count),
    .res_push (res_push),
    .res_data (res_data)
  );

  gbc_fifo #(
    .W    (RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .pop  (o_pop),
    .dout (o_dout),
    .full (o_full),
    .empty(o_empty),
    .count(o_count)
  );

  assign o_pop      = out_valid && out_ready;
  assign out_valid  = !o_empty;
  assign pixel_out  = o_dout[RES_W-1:1];
  assign frame_last = o_dout[0];

  assert property (@(posedge clk) disable iff (rst) res_push |-> !o_full)
    else $error("Output queue overflow.");

  assert property (@(posedge clk) disable iff (rst) f_push |-> !q_full)
    else $error("Op queue overflow.");

  assert property (@(posedge clk) disable iff (rst) q_pop |-> (q_count != '0))
    else $error("Op queue underflow.");

endmodule

[sv/gbc_fifo.sv]
// ----------------------------------------------------------------------------
// gbc_fifo
// Small synchronous FIFO with occupancy count; depth is a power of two.
// ----------------------------------------------------------------------------
module gbc_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [W-1:0]                     din,
  input  logic                             pop,
  output logic [W-1:0]                     dout,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CNW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[sv/gbc_front.sv]
// ----------------------------------------------------------------------------
// gbc_front
// Accepts items, tracks frame position and classifies each step for the back.
// ----------------------------------------------------------------------------
module gbc_front import gbc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned CW         = 10,
  parameter int unsigned RW         = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd,
  input  logic [7:0]            pixel_in,
  input  logic                  cfg_valid,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [CW-1:0]         q_col,
  output op_ctl_t               q_ctl
);

  function automatic logic [31:0] clamp_m1(input logic [31:0] v, input logic [31:0] mx);
    if (v == 32'd0) begin
      clamp_m1 = 32'd0;
    end else if (v > mx) begin
      clamp_m1 = mx - 32'd1;
    end else begin
      clamp_m1 = v - 32'd1;
    end
  endfunction

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic [CW-1:0] in_column;
  logic [RW-1:0] in_row;
  logic [CW-1:0] out_column;
  logic [RW-1:0] out_row;

  logic row_done;
  logic r0;
  logic r1;
  logic col0;
  logic dbl_case;
  logic step_ok;
  logic emit;
  logic last;
  blur_mode_t mode;

  assign row_done = (in_row > hm1);
  assign r0       = (in_row == '0);
  assign r1       = (in_row == RW'(1));
  assign col0     = (in_column == '0);
  assign dbl_case = cmd && row_done && r1 && col0;
  assign step_ok  = cmd ? row_done : !row_done;
  assign emit     = (!r0 && !r1) || (r1 && !col0);
  assign last     = emit && (out_row == hm1) && (out_column == wm1);

  always_comb begin
    if (col0) begin
      mode = (wm1 != '0) ? BM_RIGHT : BM_ALL2;
    end else if (in_column == CW'(1)) begin
      mode = BM_LEFT;
    end else begin
      mode = BM_NORMAL;
    end
  end

  assign in_ready = !q_full && !dbl_case;
  assign q_push   = in_valid && !q_full && step_ok;
  assign q_col    = in_column;

  always_comb begin
    q_ctl.flush = cmd;
    q_ctl.r0    = r0;
    q_ctl.r1    = r1;
    q_ctl.emit  = emit;
    q_ctl.last  = last;
    q_ctl.mode  = mode;
    q_ctl.pix   = pixel_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wm1        <= CW'(clamp_m1(32'(WIDTH_RESET), 32'(MAX_WIDTH)));
      hm1        <= RW'(clamp_m1(32'(HEIGHT_RESET), 32'(MAX_HEIGHT)));
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          wm1 <= CW'(clamp_m1(32'(cfg_data[10:0]), 32'(MAX_WIDTH)));
        end
        REG_IMAGE_HEIGHT: begin
          hm1 <= RW'(clamp_m1(32'(cfg_data[12:0]), 32'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (q_push) begin
      if (last) begin
        in_column  <= '0;
        in_row     <= '0;
        out_column <= '0;
        out_row    <= '0;
      end else begin
        if (in_column == wm1) begin
          in_column <= '0;
          in_row    <= in_row + RW'(1);
        end else begin
          in_column <= in_column + CW'(1);
        end
        if (emit) begin
          if (out_column == wm1) begin
            out_column <= '0;
            out_row    <= out_row + RW'(1);
          end else begin
            out_column <= out_column + CW'(1);
          end
        end
      end
    end
  end

endmodule

[sv/gbc_back.sv]
// ----------------------------------------------------------------------------
// gbc_back
// Line stores, 3x3 window and kernel sum; one step per cycle with credit flow.
// ----------------------------------------------------------------------------
module gbc_back import gbc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  parameter int unsigned CW        = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  logic [CW-1:0]        q_col,
  input  op_ctl_t              q_ctl,
  output logic                 q_pop,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_push,
  output logic [RES_W-1:0]     res_data
);

  logic [7:0] store_a [MAX_WIDTH];
  logic [7:0] store_b [MAX_WIDTH];

  logic          a_valid;
  logic [CW-1:0] a_col;
  op_ctl_t       a_ctl;
  logic [7:0]    rd_a;
  logic [7:0]    rd_b;
  logic          fwd_hit;
  logic          fwd_b_en;
  logic [7:0]    fwd_a;
  logic [7:0]    fwd_b;
  logic [7:0]    win [9];

  logic [7:0]  a_data;
  logic [7:0]  b_data;
  logic [7:0]  pix;
  logic [7:0]  av;
  logic [7:0]  top;
  logic [7:0]  mid;
  logic [9:0]  o1;
  logic [9:0]  o2;
  logic [9:0]  nc;
  logic [9:0]  sl;
  logic [9:0]  sr;
  logic [11:0] total;

  assign q_pop = !q_empty &&
                 ((out_count + OUT_CNT_W'(a_valid)) < OUT_CNT_W'(OUT_DEPTH));

  always_comb begin
    a_data = fwd_hit ? fwd_a : rd_a;
    b_data = (fwd_hit && fwd_b_en) ? fwd_b : rd_b;
    pix    = a_ctl.flush ? a_data : a_ctl.pix;
    av     = a_ctl.r0 ? pix : a_data;
    top    = a_ctl.r0 ? pix : (a_ctl.r1 ? av : b_data);
    mid    = a_ctl.r0 ? pix : av;
    o1     = col_sum(win[3], win[4], win[5]);
    o2     = col_sum(win[6], win[7], win[8]);
    nc     = col_sum(top, mid, pix);
    sl     = (a_ctl.mode == BM_RIGHT || a_ctl.mode == BM_NORMAL) ? o1 : o2;
    sr     = (a_ctl.mode == BM_RIGHT || a_ctl.mode == BM_ALL2) ? o2 : nc;
    total  = {2'b00, sl} + {1'b0, o2, 1'b0} + {2'b00, sr};
  end

  assign res_push = a_valid && a_ctl.emit;
  assign res_data = {total[11:4], a_ctl.last};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_col    <= q_col;
      a_ctl    <= q_ctl;
      rd_a     <= store_a[q_col];
      rd_b     <= store_b[q_col];
      fwd_hit  <= a_valid && (a_col == q_col);
      fwd_a    <= pix;
      fwd_b    <= av;
      fwd_b_en <= !a_ctl.r0;
    end
    if (a_valid) begin
      store_a[a_col] <= pix;
      if (!a_ctl.r0) begin
        store_b[a_col] <= av;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= 8'd0;
      end
    end else if (a_valid) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= win[i+3];
      end
      win[6] <= top;
      win[7] <= mid;
      win[8] <= pix;
    end
  end

  assert property (@(posedge clk) disable iff (rst) res_push |-> $past(q_pop))
    else $error("Result pushed without a step issued the cycle before.");

  assert property (@(posedge clk) disable iff (rst)
                   res_push |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("Result pushed into a full output queue.");

  assert property (@(posedge clk) disable iff (rst) (a_valid && a_ctl.flush) |-> !a_ctl.r0)
    else $error("Flush step issued from the first row.");

endmodule

[tb/tb_gaussian_blur_3x3_clamped_top.sv]
// ----------------------------------------------------------------------------
// tb_gaussian_blur_3x3_clamped_top
// Self-checking bench for the clamped 3x3 Gaussian blur.
//
// Frames of random size and content are streamed in, followed by flush
// requests. A scoreboard class models the line stores, the window and the
// frame counters, and checks every result against its own prediction. Both
// sides stall at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_gaussian_blur_3x3_clamped_top import gbc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LINE_MAX   = 1024;
  localparam int unsigned ROWS_MAX   = 4096;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_LEN   = 300;

  typedef struct {
    logic [7:0] pix;
    logic       last;
  } blur_result_t;

  class BlurScoreboard;
    logic [7:0]   row_above[LINE_MAX];
    logic [7:0]   row_above2[LINE_MAX];
    logic [7:0]   win[9];
    int unsigned  in_col, in_row, out_col, out_row;
    logic [10:0]  width_reg;
    logic [12:0]  height_reg;
    blur_result_t blur_q[$];
    int unsigned  errors, results, requests;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      foreach (row_above[i]) row_above[i] = '0;
      foreach (row_above2[i]) row_above2[i] = '0;
      foreach (win[i]) win[i] = '0;
      width_reg  = 11'(WIDTH_RESET);
      height_reg = 13'(HEIGHT_RESET);
      restart();
      blur_q.delete();
    endfunction

    function void restart();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function int unsigned eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > ROWS_MAX) return ROWS_MAX;
      return height_reg;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[10:0];
      else height_reg = data[12:0];
      restart();
    endfunction

    function int unsigned col_weight(int unsigned c);
      return win[c*3] + 2 * win[c*3+1] + win[c*3+2];
    endfunction

    function logic [7:0] kernel(int unsigned l, int unsigned m, int unsigned r);
      int unsigned s;
      s = (col_weight(l) + 2 * col_weight(m) + col_weight(r)) >> 4;
      return s[7:0];
    endfunction

    // Moves the window by one pixel; pushes a result when one is due.
    function bit shift_pixel(logic [7:0] pix);
      int unsigned w, h, c, r;
      bit           emit;
      logic [7:0]   val, above, top, mid;
      blur_result_t res;
      w = eff_w(); h = eff_h(); c = in_col; r = in_row;
      emit = (r >= 2) || (r == 1 && c >= 1);
      val = '0;
      if (emit && c == 0) val = kernel(w >= 2 ? 1 : 2, 2, 2);
      above = (r >= 1) ? row_above[c] : pix;
      if (r == 0) begin
        top = pix; mid = pix;
      end else if (r == 1) begin
        top = above; mid = above;
      end else begin
        top = row_above2[c]; mid = above;
      end
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top; win[7] = mid; win[8] = pix;
      if (r >= 1) row_above2[c] = above;
      row_above[c] = pix;
      if (emit && c == 1) val = kernel(1, 1, 2);
      else if (emit && c >= 2) val = kernel(0, 1, 2);
      if (c + 1 >= w) begin
        in_col = 0; in_row = r + 1;
      end else begin
        in_col = c + 1;
      end
      if (!emit) return 0;
      res.pix  = val;
      res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
      blur_q.push_back(res);
      if (res.last) restart();
      else if (out_col + 1 >= w) begin
        out_col = 0; out_row++;
      end else begin
        out_col++;
      end
      return 1;
    endfunction

    function void note_request(logic flush, logic [7:0] pix);
      requests++;
      if (!flush) begin
        if (in_row < eff_h()) void'(shift_pixel(pix));
        return;
      end
      if (in_row < eff_h() || in_col >= eff_w()) return;
      if (shift_pixel(row_above[in_col])) return;
      if (in_col >= eff_w()) return;
      void'(shift_pixel(row_above[in_col]));
    endfunction

    function void check_result(logic [7:0] pix, logic last);
      blur_result_t exp_res;
      results++;
      if (blur_q.size() == 0) begin
        $display("%0t: unexpected result pixel_out=%0d frame_last=%0b", $time, pix, last);
        errors++;
        return;
      end
      exp_res = blur_q.pop_front();
      if (pix !== exp_res.pix) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, exp_res.pix, pix);
        errors++;
      end
      if (last !== exp_res.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, exp_res.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  cmd = 1'b0;
  logic [7:0]            pixel_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            pixel_out;
  logic                  frame_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [0:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  BlurScoreboard sb = new();
  bit            no_gaps = 1'b0;
  bit            hold_out = 1'b0;
  int unsigned   idle_cycles = 0;
  int unsigned   frames = 0;

  always #5 clk = ~clk;

  gaussian_blur_3x3_clamped_top i_dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .pixel_in,
    .out_valid, .out_ready, .pixel_out, .frame_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.note_request(cmd, pixel_in);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (out_valid && out_ready) sb.check_result(pixel_out, frame_last);
      if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_out) begin
        out_ready = 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_out = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_req(input logic flush, input logic [7:0] pix);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    cmd      = flush;
    pixel_in = pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.blur_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Full frame; noise adds flush requests mid-frame and pixels while draining.
  task automatic run_frame(input int unsigned w, input int unsigned h, input bit noise);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : w;
    eh = (h == 0) ? 1 : h;
    write_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    if (frames == 20) hold_out = 1'b1;
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if (noise && $urandom_range(0, 19) == 0) send_req(1'b1, 8'($urandom_range(0, 255)));
      send_req(1'b0, rand_pixel());
    end
    for (int unsigned i = 0; i < ew + 2; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_req(1'b0, rand_pixel());
      send_req(1'b1, 8'($urandom_range(0, 255)));
    end
    frames++;
  endtask

  task automatic partial_frame(input logic [CFG_DATA_W-1:0] wdata,
                               input logic [CFG_DATA_W-1:0] hdata, input int unsigned n);
    write_cfg(REG_IMAGE_WIDTH, wdata);
    write_cfg(REG_IMAGE_HEIGHT, hdata);
    for (int unsigned i = 0; i < n; i++) send_req(1'b0, rand_pixel());
  endtask

  initial begin
    int unsigned w, h;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Flush with nothing pending, then extremes of size and level.
    send_req(1'b1, 8'hFF);
    run_frame(3, 3, 1'b0);
    run_frame(0, 0, 1'b0);
    run_frame(1, 4, 1'b0);
    run_frame(5, 1, 1'b0);
    run_frame(2, 2, 1'b1);
    partial_frame(13'h1FFF, 13'd2, 30);
    partial_frame(13'd3, 13'h1FFF, 20);
    partial_frame(13'd1024, 13'd1, 12);

    while (sb.requests < 1900) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if (frames == 20) begin
        w = 12;
        h = 8;
      end else if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
      end
      run_frame(w, h, $urandom_range(0, 2) == 0);
    end

    no_gaps = 1'b0;
    wait_idle();
    repeat (20) @(negedge clk);
    $display("Covered %0d frames with %0d requests and %0d results.",
             frames, sb.requests, sb.results);
    if (sb.errors == 0 && sb.blur_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.blur_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
